// ===== design/pnsra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsra_pkg
// Shared constants, types and helpers of the stencil row assembler.
// ----------------------------------------------------------------------------
package pnsra_pkg;

  localparam int MAX_NODES = 4096;
  localparam int SLOTS     = 6;
  localparam int DEPTH     = MAX_NODES * SLOTS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int NODE_W    = 12;
  localparam int DIR_W     = 3;
  localparam int PERM_W    = 32;
  localparam int VALUE_W   = 37;
  localparam int SUM_W     = PERM_W + 1;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_ASSEMBLE = 1'b1;

  localparam logic MODE_2D = 1'b0;
  localparam logic MODE_3D = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic cap_own;
    logic sel_far;
    logic emit_dir;
    logic emit_diag;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic asm_go;
    logic last_dir;
    logic out_free;
  } status_t;

  function automatic logic [DIR_W-1:0] opposite_dir(input logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] o;
    case (d)
      3'd0:    o = 3'd2;
      3'd1:    o = 3'd3;
      3'd2:    o = 3'd0;
      3'd3:    o = 3'd1;
      3'd4:    o = 3'd5;
      3'd5:    o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [NODE_W-1:0] n,
                                                  input logic [DIR_W-1:0] d);
    return ADDR_W'(32'(n) * SLOTS + 32'(d));
  endfunction

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return 32'(n) < MAX_NODES;
  endfunction

endpackage
`default_nettype wire

// ===== design/pnsra_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsra_ctrl
// Sequencer: per direction read own slot, capture, read far slot, emit; then emit the diagonal.
// ----------------------------------------------------------------------------
module pnsra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire pnsra_pkg::status_t status,
  output pnsra_pkg::cmd_t        cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OWN  = 3'd1;
  localparam logic [2:0] S_CAP  = 3'd2;
  localparam logic [2:0] S_FAR  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_DIAG = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && status.asm_go) begin
          cmd.start  = 1'b1;
          state_next = S_OWN;
        end
      end
      S_OWN: begin
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap_own = 1'b1;
        state_next  = S_FAR;
      end
      S_FAR: begin
        cmd.sel_far = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.sel_far = 1'b1;
        if (status.out_free) begin
          cmd.emit_dir = 1'b1;
          state_next   = status.last_dir ? S_DIAG : S_OWN;
        end
      end
      S_DIAG: begin
        if (status.out_free) begin
          cmd.emit_diag = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_OWN)
    else $error("assemble start did not enter read sequence");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_dir || cmd.emit_diag) |-> status.out_free)
    else $error("entry emitted into a full output register");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT || state == S_DIAG) |-> !s_tready)
    else $error("input ready while a row is in progress");

endmodule
`default_nettype wire

// ===== design/pnsra_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnsra_datapath
// Link stores, mode register, accumulator and output register.
// ----------------------------------------------------------------------------
module pnsra_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pnsra_pkg::cmd_t                 cmd,
  output pnsra_pkg::status_t                   status,
  input  wire logic [1:0]                      s_tuser,
  input  wire logic [63:0]                     s_tdata,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [63:0]                          m_tdata,
  output logic                                 m_tlast
);

  logic                              in_func;
  logic                              in_fixed;
  logic [pnsra_pkg::NODE_W-1:0]      in_node;
  logic [pnsra_pkg::DIR_W-1:0]       in_dir;
  logic [pnsra_pkg::NODE_W-1:0]      in_nb;
  logic [pnsra_pkg::PERM_W-1:0]      in_perm;

  assign in_func  = s_tuser[0];
  assign in_fixed = s_tuser[1];
  assign in_node  = s_tdata[11:0];
  assign in_dir   = s_tdata[14:12];
  assign in_nb    = s_tdata[26:15];
  assign in_perm  = s_tdata[58:27];

  logic                              mode;
  logic [pnsra_pkg::NODE_W-1:0]      node_r;
  logic [pnsra_pkg::DIR_W-1:0]       dir_cnt;
  logic [pnsra_pkg::NODE_W-1:0]      col_r;
  logic [pnsra_pkg::PERM_W-1:0]      own_r;
  logic [pnsra_pkg::VALUE_W-1:0]     acc;

  logic [pnsra_pkg::PERM_W-1:0]      perm_mem [pnsra_pkg::DEPTH];
  logic [pnsra_pkg::NODE_W-1:0]      nb_mem   [pnsra_pkg::DEPTH];
  logic [pnsra_pkg::PERM_W-1:0]      rd_perm;
  logic [pnsra_pkg::NODE_W-1:0]      rd_nb;

  logic                              wr_en;
  logic [pnsra_pkg::ADDR_W-1:0]      wr_addr;
  logic [pnsra_pkg::ADDR_W-1:0]      rd_addr;
  logic [pnsra_pkg::PERM_W-1:0]      far;
  logic [pnsra_pkg::SUM_W-1:0]       link_sum;
  logic [pnsra_pkg::VALUE_W-1:0]     dir_value;

  assign wr_en = cmd.accept && (in_func == pnsra_pkg::FUNC_LOAD)
                 && (in_dir < pnsra_pkg::DIR_W'(pnsra_pkg::SLOTS))
                 && pnsra_pkg::node_ok(in_node);
  assign wr_addr = pnsra_pkg::slot_addr(in_node, in_dir);
  assign rd_addr = cmd.sel_far
                   ? pnsra_pkg::slot_addr(col_r, pnsra_pkg::opposite_dir(dir_cnt))
                   : pnsra_pkg::slot_addr(node_r, dir_cnt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= in_perm;
      nb_mem[wr_addr]   <= in_nb;
    end
    rd_perm <= perm_mem[rd_addr];
    rd_nb   <= nb_mem[rd_addr];
  end

  assign far       = pnsra_pkg::node_ok(col_r) ? rd_perm : '0;
  assign link_sum  = pnsra_pkg::SUM_W'(own_r) + pnsra_pkg::SUM_W'(far);
  assign dir_value = pnsra_pkg::VALUE_W'(0) - pnsra_pkg::VALUE_W'(link_sum);

  assign status.asm_go   = (in_func == pnsra_pkg::FUNC_ASSEMBLE) && !in_fixed
                           && pnsra_pkg::node_ok(in_node);
  assign status.last_dir = dir_cnt == ((mode == pnsra_pkg::MODE_3D) ? 3'd5 : 3'd3);
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pnsra_pkg::MODE_3D;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      node_r <= in_node;
      acc    <= '0;
    end
    if (cmd.cap_own) begin
      own_r <= rd_perm;
      col_r <= rd_nb;
    end
    if (cmd.emit_dir) begin
      acc <= acc + pnsra_pkg::VALUE_W'(link_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_cnt <= '0;
    end else if (cmd.start) begin
      dir_cnt <= '0;
    end else if (cmd.emit_dir && !status.last_dir) begin
      dir_cnt <= dir_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_dir || cmd.emit_diag) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_dir) begin
      m_tdata <= {3'b000, dir_value, col_r, node_r};
      m_tlast <= 1'b0;
    end else if (cmd.emit_diag) begin
      m_tdata <= {3'b000, acc, node_r, node_r};
      m_tlast <= 1'b1;
    end
  end

  a_dir_in_range: assert property (@(posedge clk) disable iff (rst)
    dir_cnt < pnsra_pkg::DIR_W'(pnsra_pkg::SLOTS))
    else $error("direction counter out of range");

  a_diag_marks_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_diag |=> m_tvalid && m_tlast)
    else $error("diagonal beat not marked last");

  a_dir_value_nonpos: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_dir |=> (m_tdata[60] || m_tdata[60:24] == '0) && !m_tlast)
    else $error("direction entry with positive value");

endmodule
`default_nettype wire

// ===== design/pore_network_stencil_row_assembler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pore_network_stencil_row_assembler_unit
// Builds coordinate-form matrix rows of a 4/6-neighbor pore network stencil.
// ----------------------------------------------------------------------------
// Load beat: accepted, no output.
// Assemble beat: per direction (N = 4 or 6 directions) an own-slot read /
//   capture / far-slot read / emit step on the single read port of the link
//   stores, then the diagonal entry; emits stall while the output register is full.
// Fixed or out-of-range nodes: accepted, no output.
// Reset clears control and sets dimension_mode to 1; stores are not cleared.
module pore_network_stencil_row_assembler_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // node[11:0] dir[14:12] neighbor[26:15] link_perm[58:27]
  input  wire logic [1:0]  s_tuser,   // func[0] fixed_node[1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // row[11:0] col[23:12] value[60:24]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data   // dimension_mode
);

  pnsra_pkg::cmd_t    cmd;
  pnsra_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pnsra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pnsra_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
